FILE: rtl/core/mtd_pkg.sv
// Shared types and constants for the trial-division Mobius block.
// No dependencies; imported by every module of the block.
package mtd_pkg;

  localparam int unsigned IN_VALUE_W     = 20;
  localparam int unsigned MU_W           = 2;
  localparam int unsigned VALUE_BITS_DEF = 20;

  localparam logic signed [MU_W-1:0] MU_ZERO = 2'sb00;
  localparam logic signed [MU_W-1:0] MU_POS  = 2'sb01;
  localparam logic signed [MU_W-1:0] MU_NEG  = 2'sb11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV1,
    ST_START2,
    ST_DIV2,
    ST_FINISH
  } mtd_state_t;

endpackage

FILE: rtl/core/mtd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on mtd_pkg (imported for the default of VALUE_BITS).
module mtd_div
  import mtd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quot,
  output logic [VALUE_BITS-1:0] remd
);

  localparam int unsigned CW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [VALUE_BITS-1:0] r_r, r_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   diff;
  logic                  ge;

  assign shifted = {r_r, q_r[VALUE_BITS-1]};
  assign ge      = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      q_nxt   = {q_r[VALUE_BITS-2:0], ge};
      r_nxt   = ge ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(VALUE_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign remd = r_r;

endmodule

FILE: rtl/core/mtd_ctrl.sv
// Trial-division sequencer: walks divisors, tracks sign and square factors.
// Depends on mtd_pkg and drives one mtd_div instance through its ports.
module mtd_ctrl
  import mtd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_BITS-1:0]  value,
  output logic                   idle,
  output logic                   res_valid,
  output logic signed [MU_W-1:0] res_mu,
  input  logic                   res_take,
  output logic                   div_start,
  output logic [VALUE_BITS-1:0]  div_dividend,
  output logic [VALUE_BITS-1:0]  div_divisor,
  input  logic                   div_done,
  input  logic [VALUE_BITS-1:0]  div_quot,
  input  logic [VALUE_BITS-1:0]  div_remd
);

  localparam int unsigned SQW = VALUE_BITS + 2;

  mtd_state_t            state_r, state_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] d_r, d_nxt;
  logic [SQW-1:0]        sq_r, sq_nxt;
  logic                  neg_r, neg_nxt;
  logic                  zero_r, zero_nxt;
  logic                  sq_le;
  logic                  rem_zero;

  assign sq_le    = sq_r <= SQW'(rem_r);
  assign rem_zero = div_remd == '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = (value == '0) ? ST_FINISH : ST_CHECK;
      ST_CHECK:  state_nxt = sq_le ? ST_DIV1 : ST_FINISH;
      ST_DIV1:   if (div_done) state_nxt = rem_zero ? ST_START2 : ST_CHECK;
      ST_START2: state_nxt = ST_DIV2;
      ST_DIV2:   if (div_done) state_nxt = rem_zero ? ST_FINISH : ST_CHECK;
      ST_FINISH: if (res_take) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rem_nxt   = rem_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    neg_nxt   = neg_r;
    zero_nxt  = zero_r;
    div_start = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          rem_nxt  = value;
          d_nxt    = VALUE_BITS'(2);
          sq_nxt   = SQW'(4);
          neg_nxt  = 1'b0;
          zero_nxt = value == '0;
        end
      end
      ST_CHECK: begin
        div_start = sq_le;
      end
      ST_DIV1: begin
        if (div_done) begin
          if (rem_zero) begin
            // divide the factor out once and test it again
            rem_nxt = div_quot;
            neg_nxt = ~neg_r;
          end else begin
            d_nxt  = d_r + 1'b1;
            sq_nxt = sq_r + SQW'({d_r, 1'b1});
          end
        end
      end
      ST_START2: begin
        div_start = 1'b1;
      end
      ST_DIV2: begin
        if (div_done) begin
          if (rem_zero) begin
            zero_nxt = 1'b1;
          end else begin
            d_nxt  = d_r + 1'b1;
            sq_nxt = sq_r + SQW'({d_r, 1'b1});
          end
        end
      end
      ST_FINISH: begin
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // leftover remainder above one is one more prime
  always_comb begin
    if (zero_r) begin
      res_mu = MU_ZERO;
    end else if (neg_r ^ (rem_r > VALUE_BITS'(1))) begin
      res_mu = MU_NEG;
    end else begin
      res_mu = MU_POS;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    d_r    <= d_nxt;
    sq_r   <= sq_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle         = state_r == ST_IDLE;
  assign div_dividend = rem_r;
  assign div_divisor  = d_r;

endmodule

FILE: rtl/core/mobius_trial_division.sv
// Top level of the trial-division Mobius block: input capture, output register.
// Depends on mtd_pkg, mtd_ctrl and mtd_div.
//
// Usage:
//   Input channel in_valid / in_stall / in_value carries one integer per beat;
//   only the low VALUE_BITS bits are used. Output channel out_valid /
//   out_stall / out_mobius returns one signed 2-bit value per input beat:
//   1, -1 (bits 11) or 0 when the integer has a square factor or is zero.
//   One item is in work at a time; in_stall stays high from the beat that is
//   taken until its result has moved into the output register.
//   Timing: each candidate divisor d with d*d <= remainder costs a check state
//   plus one bit-serial division; a divisor that divides adds a start state and
//   a second division. The run time grows with sqrt(n) and is set by the serial
//   divider; the next beat can be taken in the cycle after the result leaves.
//   While the receiver stalls, the output register holds its beat and a new
//   item is still taken; a finished result then waits in the sequencer.
//   Reset (synchronous, active low) empties the output register and returns
//   the sequencer to idle.
module mobius_trial_division
  import mtd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [IN_VALUE_W-1:0]  in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [MU_W-1:0] out_mobius
);

  logic [VALUE_BITS-1:0]  value;
  logic                   idle;
  logic                   res_valid;
  logic signed [MU_W-1:0] res_mu;
  logic                   res_take;
  logic                   div_start;
  logic [VALUE_BITS-1:0]  div_dividend;
  logic [VALUE_BITS-1:0]  div_divisor;
  logic                   div_done;
  logic [VALUE_BITS-1:0]  div_quot;
  logic [VALUE_BITS-1:0]  div_remd;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [MU_W-1:0] out_mu_r, out_mu_nxt;

  if (VALUE_BITS > IN_VALUE_W) begin : g_wide
    assign value = {{(VALUE_BITS - IN_VALUE_W){1'b0}}, in_value};
  end else begin : g_narrow
    assign value = in_value[VALUE_BITS-1:0];
  end

  assign in_stall = ~idle;
  assign res_take = ~out_valid_r | ~out_stall;

  mtd_ctrl #(.VALUE_BITS(VALUE_BITS)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_valid),
    .value        (value),
    .idle         (idle),
    .res_valid    (res_valid),
    .res_mu       (res_mu),
    .res_take     (res_take),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quot     (div_quot),
    .div_remd     (div_remd)
  );

  mtd_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .remd     (div_remd)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_mu_nxt    = out_mu_r;
    if (res_take) begin
      // load the finished beat, or drop the one just taken
      out_valid_nxt = res_valid;
      out_mu_nxt    = res_mu;
    end
  end

  always_ff @(posedge clk) begin
    out_mu_r <= out_mu_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_mobius = out_mu_r;

endmodule

FILE: rtl/core/mtd_chk.sv
// Port-level checker for mobius_trial_division, bound to the top level.
// Depends on mtd_pkg for the field widths and result codes.
module mtd_chk
  import mtd_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic [IN_VALUE_W-1:0]  in_value,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic signed [MU_W-1:0] out_mobius
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mobius))
    else $error("stalled output beat changed");

  a_mu_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mobius == MU_ZERO || out_mobius == MU_POS || out_mobius == MU_NEG)
    else $error("result code out of range");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while an item is in work");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_value_seen: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_value == '0 |=> in_stall)
    else $error("zero input not held as busy");

endmodule

bind mobius_trial_division mtd_chk u_chk (.*);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for mobius_trial_division: directed table, then random beats.
// Depends on mtd_pkg and the block's RTL; predicts each Mobius value by trial division.
module tb;
  import mtd_pkg::*;

  localparam int unsigned VALUE_BITS = VALUE_BITS_DEF;
  localparam int          HOLD_LEN   = 3000;
  localparam int          N_DIR      = 17;

  typedef struct {
    logic [IN_VALUE_W-1:0]  value;
    bit                     typed;
    logic signed [MU_W-1:0] mu;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [IN_VALUE_W-1:0]  in_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [MU_W-1:0] out_mobius;

  logic signed [MU_W-1:0] mu_pending [$];
  int                     mismatch_count = 0;
  int                     idle_pct = 0;
  int                     stall_pct = 0;
  int                     hold_req = 0;

  // small values first, then large values up to the top of the 20-bit range
  stim_row_t dir_rows [N_DIR] = '{
    '{20'd1,       1'b1, MU_POS},
    '{20'd0,       1'b1, MU_ZERO},
    '{20'd2,       1'b1, MU_NEG},
    '{20'd3,       1'b1, MU_NEG},
    '{20'd4,       1'b1, MU_ZERO},
    '{20'd6,       1'b1, MU_POS},
    '{20'd30,      1'b1, MU_NEG},
    '{20'd9,       1'b1, MU_ZERO},
    '{20'hFFFFF,   1'b0, MU_ZERO},
    '{20'd1048573, 1'b0, MU_ZERO},
    '{20'd1048574, 1'b0, MU_ZERO},
    '{20'h80000,   1'b0, MU_ZERO},
    '{20'd1042441, 1'b0, MU_ZERO},
    '{20'd1040399, 1'b0, MU_ZERO},
    '{20'd510510,  1'b0, MU_ZERO},
    '{20'hAAAAA,   1'b0, MU_ZERO},
    '{20'h55555,   1'b0, MU_ZERO}
  };

  mobius_trial_division #(.VALUE_BITS(VALUE_BITS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_mobius (out_mobius)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic signed [MU_W-1:0] mu_by_trial(input logic [IN_VALUE_W-1:0] value);
    longint unsigned rem;
    longint unsigned d;
    bit              neg;
    rem = longint'(value) & ((64'd1 << VALUE_BITS) - 1);
    neg = 1'b0;
    if (rem == 0) return MU_ZERO;
    for (d = 2; d * d <= rem; d++) begin
      if (rem % d == 0) begin
        neg = !neg;
        rem = rem / d;
        if (rem % d == 0) return MU_ZERO;
      end
    end
    if (rem > 1) neg = !neg;
    return neg ? MU_NEG : MU_POS;
  endfunction

  // mostly small values; a share with the low bits clear to exercise the upper bits
  // cheaply, and a few full-width ones that run the long scan
  function automatic logic [IN_VALUE_W-1:0] pick_value();
    int unsigned           sel;
    logic [IN_VALUE_W-1:0] v;
    sel = $urandom_range(99);
    v = IN_VALUE_W'($urandom);
    if (sel < 2) v = '0;
    else if (sel < 66) v = IN_VALUE_W'($urandom_range(4095, 1));
    else if (sel < 84) v[1:0] = 2'b00;
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR: %s at %0t", what, $realtime);
    mismatch_count++;
  endtask

  task automatic send_value(input logic [IN_VALUE_W-1:0] v, input logic signed [MU_W-1:0] mu);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mu_pending.push_back(mu);
  endtask

  task automatic send_random(input int count);
    logic [IN_VALUE_W-1:0] v;
    for (int i = 0; i < count; i++) begin
      v = pick_value();
      send_value(v, mu_by_trial(v));
    end
  endtask

  // receiver: check each beat taken, then pick the next stall
  initial begin
    int                     hold_left;
    logic signed [MU_W-1:0] want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (mu_pending.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", out_mobius));
        end else begin
          want = mu_pending.pop_front();
          if (out_mobius !== want)
            report_mismatch($sformatf("mobius %0d, expected %0d", out_mobius, want));
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    logic signed [MU_W-1:0] mu;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      mu = dir_rows[i].typed ? dir_rows[i].mu : mu_by_trial(dir_rows[i].value);
      send_value(dir_rows[i].value, mu);
    end

    idle_pct = 46;
    send_random(25);

    idle_pct = 0;
    stall_pct = 46;
    send_random(20);

    // hold the output off while small beats keep coming, so the input backs up
    stall_pct = 0;
    hold_req = HOLD_LEN;
    for (int i = 0; i < 10; i++) begin
      send_value(20'(i * 23 + 4), mu_by_trial(20'(i * 23 + 4)));
    end

    // drain completely before the next phase
    in_valid <= 1'b0;
    while (mu_pending.size() != 0) @(posedge clk);

    idle_pct = 16;
    stall_pct = 16;
    send_random(25);

    in_valid <= 1'b0;
    while (mu_pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/mtd_pkg.sv
rtl/core/mtd_div.sv
rtl/core/mtd_ctrl.sv
rtl/core/mobius_trial_division.sv
rtl/core/mtd_chk.sv
verif/tb.sv
